### hw/rtl/keypad_code_lock_lockout_top_macros.svh
// Assertion macros shared by the keypad code lock RTL.
`ifndef KEYPAD_CODE_LOCK_LOCKOUT_TOP_MACROS_SVH
`define KEYPAD_CODE_LOCK_LOCKOUT_TOP_MACROS_SVH

// Checked on every edge outside reset.
`define KCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define KCL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/kcl_pkg.sv
// Package for the keypad code lock: sizes, register indexes, verdict codes and types.
`timescale 1ns / 1ps

package kcl_pkg;

    // keys per entry and derived widths
    localparam int CODE_LENGTH = 4;
    localparam int KEY_W       = 4;
    localparam int ENTRY_W     = KEY_W * CODE_LENGTH;
    localparam int CNT_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int TIMER_W     = 16;
    localparam int ATT_W       = 4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SECRET_CODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ATTEMPTS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCKOUT_TICKS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_PERIOD  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_ON      = 3'd5;

    // verdict codes
    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_CORRECT = 2'd1;
    localparam logic [1:0] VERDICT_WRONG   = 2'd2;
    localparam logic [1:0] VERDICT_LOCKED  = 2'd3;

    // item kinds
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [ATT_W-1:0]   ATT_MAX   = '1;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] secret_code;
        logic [ATT_W-1:0]      max_attempts;
        logic [TIMER_W-1:0]    lockout_ticks;
        logic [TIMER_W-1:0]    hold_ticks;
        logic [TIMER_W-1:0]    blink_period;
        logic [TIMER_W-1:0]    blink_on;
    } t_cfg;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key_code;
    } t_item;

    typedef struct packed {
        logic             key_taken;
        logic [ATT_W-1:0] attempts;
        logic [1:0]       verdict;
        logic             locked;
        logic             red_led;
        logic             green_led;
    } t_result;

    // secret code widened or cut to the entry width; unused key slots read as zero
    function automatic logic [ENTRY_W-1:0] secret_to_entry(input logic [CFG_DATA_W-1:0] code);
        logic [ENTRY_W+CFG_DATA_W-1:0] ext;
        ext = {{ENTRY_W{1'b0}}, code};
        return ext[ENTRY_W-1:0];
    endfunction

endpackage

### hw/rtl/kcl_cfg.sv
// Configuration register bank of the keypad code lock.
`timescale 1ns / 1ps

module kcl_cfg
    import kcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.secret_code   <= 16'h1234;
            r_cfg.max_attempts  <= 4'd3;
            r_cfg.lockout_ticks <= 16'd5000;
            r_cfg.hold_ticks    <= 16'd1000;
            r_cfg.blink_period  <= 16'd500;
            r_cfg.blink_on      <= 16'd250;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SECRET_CODE:   r_cfg.secret_code   <= i_cfg_wdata;
                REG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= i_cfg_wdata[ATT_W-1:0];
                REG_LOCKOUT_TICKS: r_cfg.lockout_ticks <= i_cfg_wdata[TIMER_W-1:0];
                REG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_wdata[TIMER_W-1:0];
                REG_BLINK_PERIOD:  r_cfg.blink_period  <= i_cfg_wdata[TIMER_W-1:0];
                REG_BLINK_ON:      r_cfg.blink_on      <= i_cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/kcl_core.sv
// Lock state and the single-pass update for one key press or tick.
`timescale 1ns / 1ps

module kcl_core
    import kcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [CNT_W-1:0]   r_entry_count, n_entry_count;
    logic [ENTRY_W-1:0] r_entry_keys,  n_entry_keys;
    logic [ATT_W-1:0]   r_attempts,    n_attempts;
    logic               r_lock,        n_lock;
    logic [TIMER_W-1:0] r_elapsed,     n_elapsed;
    logic [TIMER_W-1:0] r_hold,        n_hold;
    logic [1:0]         r_shown,       n_shown;
    logic [TIMER_W-1:0] r_phase,       n_phase;

    logic [ENTRY_W+KEY_W-1:0] keys_shift;
    logic [ENTRY_W-1:0]       keys_new;
    logic [ATT_W-1:0]         att_inc;
    logic [TIMER_W-1:0]       elapsed_inc;
    logic [TIMER_W:0]         phase_inc;
    logic [1:0]               verdict_now;
    logic                     taken;

    always_comb begin
        n_entry_count = r_entry_count;
        n_entry_keys  = r_entry_keys;
        n_attempts    = r_attempts;
        n_lock        = r_lock;
        n_elapsed     = r_elapsed;
        n_hold        = r_hold;
        n_shown       = r_shown;
        n_phase       = r_phase;
        verdict_now   = VERDICT_NONE;
        taken         = 1'b0;

        keys_shift  = {r_entry_keys, i_item.key_code};
        keys_new    = keys_shift[ENTRY_W-1:0];
        att_inc     = (r_attempts != ATT_MAX) ? r_attempts + 1'b1 : r_attempts;
        elapsed_inc = (r_elapsed != TIMER_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        phase_inc   = {1'b0, r_phase} + 1'b1;

        if (i_item.mode == MODE_KEY) begin
            if (!r_lock && r_hold == '0) begin
                taken         = 1'b1;
                n_entry_keys  = keys_new;
                n_entry_count = r_entry_count + 1'b1;
                if (r_entry_count == CNT_W'(CODE_LENGTH - 1)) begin
                    if (keys_new == secret_to_entry(i_cfg.secret_code)) begin
                        verdict_now = VERDICT_CORRECT;
                        n_attempts  = '0;
                    end else begin
                        n_attempts = att_inc;
                        if (att_inc >= i_cfg.max_attempts) begin
                            n_lock      = 1'b1;
                            n_elapsed   = '0;
                            n_phase     = '0;
                            verdict_now = VERDICT_LOCKED;
                        end else begin
                            verdict_now = VERDICT_WRONG;
                        end
                    end
                    n_entry_count = '0;
                    n_entry_keys  = '0;
                    n_hold        = i_cfg.hold_ticks;
                    n_shown       = (i_cfg.hold_ticks != '0) ? verdict_now : VERDICT_NONE;
                end
            end
        end else begin
            if (r_hold != '0) begin
                n_hold = r_hold - 1'b1;
                if (r_hold == TIMER_W'(1)) begin
                    n_shown = VERDICT_NONE;
                end
            end
            if (r_lock) begin
                if (elapsed_inc >= i_cfg.lockout_ticks) begin
                    n_lock     = 1'b0;
                    n_attempts = '0;
                    n_elapsed  = '0;
                    n_phase    = '0;
                end else if (i_cfg.blink_period > TIMER_W'(1)) begin
                    n_elapsed = elapsed_inc;
                    n_phase   = (phase_inc >= {1'b0, i_cfg.blink_period}) ?
                                '0 : phase_inc[TIMER_W-1:0];
                end else begin
                    n_elapsed = elapsed_inc;
                    n_phase   = '0;
                end
            end
        end
    end

    // lamps and flags follow the state left by this item
    always_comb begin
        o_result.green_led = (n_shown == VERDICT_CORRECT);
        o_result.red_led   = (n_shown == VERDICT_WRONG) || (n_shown == VERDICT_LOCKED) ||
                             ((n_shown == VERDICT_NONE) && n_lock &&
                              (n_phase < i_cfg.blink_on));
        o_result.locked    = n_lock;
        o_result.verdict   = (verdict_now != VERDICT_NONE) ? verdict_now : n_shown;
        o_result.attempts  = n_attempts;
        o_result.key_taken = taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_entry_keys  <= '0;
            r_attempts    <= '0;
            r_lock        <= 1'b0;
            r_elapsed     <= '0;
            r_hold        <= '0;
            r_shown       <= VERDICT_NONE;
            r_phase       <= '0;
        end else if (i_en) begin
            r_entry_count <= n_entry_count;
            r_entry_keys  <= n_entry_keys;
            r_attempts    <= n_attempts;
            r_lock        <= n_lock;
            r_elapsed     <= n_elapsed;
            r_hold        <= n_hold;
            r_shown       <= n_shown;
            r_phase       <= n_phase;
        end
    end

endmodule

### hw/rtl/keypad_code_lock_lockout_top.sv
// Top level of the keypad code lock: input register, core, result register, config bank.
//
// Usage
//   Slave stream: one transaction per key press or one-millisecond tick.
//     s_axis_tuser[0] is the kind (0 key press, 1 tick), s_axis_tdata[3:0] the key code.
//   Master stream: one result transaction per input transaction, in order, with the
//     lamp drives, lock flag, verdict, attempt count and key-taken flag.
//   Config: i_cfg_we writes i_cfg_wdata to register i_cfg_addr (0 secret code,
//     1 max attempts, 2 lockout ticks, 3 hold ticks, 4 blink period, 5 blink on).
//     Write only while the block is idle; indexes 6 and 7 are ignored.
// Timing
//   An input transaction lands in the input register; when the result register is free
//   or draining, it passes through the update logic into the result register and is
//   offered on the master stream. Throughput is one transaction per cycle while the
//   master does not stall; the update of the lock state is a single shallow pass
//   (one 16-bit increment or decrement and compare per timer) per item.
// Reset
//   Synchronous, active low: both registers empty, lock state cleared, config
//   back to code 1234, 3 attempts, 5000/1000 ticks, blink 500 with 250 on.
// Stall
//   A stalled master holds the result; the input register then fills and
//   s_axis_tready drops until the result is taken. No transaction is lost.
`timescale 1ns / 1ps

module keypad_code_lock_lockout_top
    import kcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [3:0] key_code, [7:4] zero
    input  logic [0:0]            s_axis_tuser,   // [0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] green_led, [1] red_led, [2] locked, [4:3] verdict, [8:5] attempts,
    // [9] key_taken, [15:10] zero
    output logic [15:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_result core_result;
    t_result r_result;
    logic    r_out_vld;
    logic    advance;

    // item moves into the core when the result register is free or draining
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.mode     <= s_axis_tuser[0];
            r_item.key_code <= s_axis_tdata[KEY_W-1:0];
        end
    end

    kcl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kcl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_result.key_taken, r_result.attempts, r_result.verdict,
                            r_result.locked, r_result.red_led, r_result.green_led};

`include "keypad_code_lock_lockout_top_macros.svh"

    // both lamps never lit together
    `KCL_ASSERT(a_lamps_exclusive, r_out_vld |-> !(r_result.green_led && r_result.red_led), "green and red lit together")

    // a key whose check starts the lockout leaves the lock flag set
    `KCL_ASSERT(a_lock_verdict, (r_out_vld && r_result.key_taken && r_result.verdict == VERDICT_LOCKED) |-> r_result.locked, "lock verdict without lock")

    // a held correct verdict means the attempt count was cleared
    `KCL_ASSERT(a_green_clears, (r_out_vld && r_result.green_led) |-> (r_result.attempts == '0), "green with attempts counted")

    // nothing is offered in the cycle after reset
    `KCL_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!m_axis_tvalid && s_axis_tready), "pipeline not empty after reset")

endmodule
